// File: design/tlseq_pkg.sv
// ============================================================================
// tlseq_pkg: shared types and constants of the traffic light sequencer
// Holds the field widths, colour codes, register indexes, reset timings and
// the structures that pass between the sequencer modules.
// ============================================================================
package tlseq_pkg;

    localparam int MAX_LIGHTS     = 4;
    localparam int DEF_NUM_LIGHTS = 4;

    localparam int TIME_W = 8;    // width of one timing register
    localparam int CNT_W  = 12;   // width of a light countdown (signed)
    localparam int CYC_W  = 11;   // width of the cycle countdown
    localparam int ADDR_W = 5;    // byte address of five 32-bit registers
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;    // register index taken from paddr[4:2]

    // A countdown of all ones is -1: the light holds its colour.
    localparam logic [CNT_W-1:0] CNT_HOLD = {CNT_W{1'b1}};

    localparam logic [TIME_W-1:0] RST_GREEN = 8'd10;
    localparam logic [TIME_W-1:0] RST_AMBER = 8'd2;

    typedef enum logic [1:0] {
        COL_GREEN  = 2'd0,
        COL_RED    = 2'd1,
        COL_YELLOW = 2'd2
    } t_colour;

    localparam logic [IDX_W-1:0] REG_GREEN_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_GREEN_1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_2 = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_3 = 3'd3;
    localparam logic [IDX_W-1:0] REG_AMBER   = 3'd4;

    // Timing registers as seen by the sequencing logic.
    typedef struct packed {
        logic [MAX_LIGHTS-1:0][TIME_W-1:0] green;
        logic [TIME_W-1:0]                 amber;
    } t_cfg;

    // Update command for one light in the current cycle.
    typedef struct packed {
        logic advance;
        logic reload;
    } t_step;

endpackage

// File: design/four_way_traffic_light_sequencer.sv
// ============================================================================
// four_way_traffic_light_sequencer: timed sequencer for a road crossing
// Steps up to four lights through green, yellow and red on timer ticks and
// reports every light's colour and countdown plus the cycle countdown.
// ============================================================================
// Usage:
// The input channel (i_in_valid, o_in_stall, i_tick) carries one transaction
// per timer event. A tick of one advances the sequence; a tick of zero leaves
// the state alone but still yields a report. Every input transaction gives
// exactly one output transaction (o_out_valid, i_out_stall) carrying the
// colours, the countdowns and the cycle countdown after that tick.
// An accepted transaction is held in the input register and is then
// handed to the output register, from which the receiver takes the
// result. A new transaction is taken every cycle while the receiver
// does not stall. When the receiver stalls, the waiting result holds and
// one more input transaction is taken into the input register; after that
// o_in_stall rises until the output is taken. The light state only moves
// when a result is handed to the output, so the state registers also serve
// as the result register. Reset clears the channels, loads the default
// timings (green 10, amber 2) and performs one reload from them. Timing
// registers are written through the APB port and take effect at the next
// reload or at the next colour change of a light.
// ============================================================================
module four_way_traffic_light_sequencer #(
    parameter int NUM_LIGHTS = tlseq_pkg::DEF_NUM_LIGHTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlseq_pkg::ADDR_W-1:0] paddr,
    input  logic [tlseq_pkg::DATA_W-1:0] pwdata,
    output logic [tlseq_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    // Input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_tick,
    // Output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_colour_0,
    output logic [1:0]                   o_colour_1,
    output logic [1:0]                   o_colour_2,
    output logic [1:0]                   o_colour_3,
    output logic signed [tlseq_pkg::CNT_W-1:0] o_remaining_0,
    output logic signed [tlseq_pkg::CNT_W-1:0] o_remaining_1,
    output logic signed [tlseq_pkg::CNT_W-1:0] o_remaining_2,
    output logic signed [tlseq_pkg::CNT_W-1:0] o_remaining_3,
    output logic [tlseq_pkg::CYC_W-1:0]  o_cycle_remaining
);
    import tlseq_pkg::*;

    // Cycle length after reset: every light gets one green and one amber.
    localparam logic [CYC_W-1:0] L_RST_CYCLE =
        CYC_W'(NUM_LIGHTS * (int'(RST_GREEN) + int'(RST_AMBER)));

    t_cfg               w_cfg;

    // Input register and output handshake state.
    logic               r_s1_valid;
    logic               n_s1_valid;
    logic               r_s1_tick;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_out_free;
    logic               w_s1_move;
    logic               w_accept;

    // Sequencing control.
    logic [CYC_W-1:0]   r_cycle;
    logic [CYC_W-1:0]   n_cycle;
    logic               w_cycle_zero;
    t_step              w_step;

    // w_wait[k] is the summed green and amber time of the lights before k.
    logic [NUM_LIGHTS:0][CNT_W-1:0]     w_wait;
    logic [MAX_LIGHTS-1:0][1:0]         w_colour;
    logic [MAX_LIGHTS-1:0][CNT_W-1:0]   w_count;

    tlseq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The input register moves on whenever the output register is empty or
    // its transaction is being taken in this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_move) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = w_out_free ? w_s1_move : r_out_valid;
    end

    // A tick that finds the cycle count at zero reloads the whole pattern
    // and leaves the lights otherwise untouched; any other tick of one advances.
    assign w_cycle_zero   = (r_cycle == '0);
    assign w_step.reload  = w_s1_move && r_s1_tick && w_cycle_zero;
    assign w_step.advance = w_s1_move && r_s1_tick && !w_cycle_zero;

    assign w_wait[0] = '0;
    genvar k;
    generate
        for (k = 0; k < NUM_LIGHTS; k++) begin : g_wait
            assign w_wait[k+1] = w_wait[k] + CNT_W'(w_cfg.green[k])
                               + CNT_W'(w_cfg.amber);
        end
    endgenerate

    always_comb begin
        n_cycle = r_cycle;
        if (w_step.reload) begin
            n_cycle = w_wait[NUM_LIGHTS][CYC_W-1:0];
        end else if (w_step.advance) begin
            n_cycle = r_cycle - 1'b1;
        end
    end

    generate
        for (k = 0; k < MAX_LIGHTS; k++) begin : g_light
            if (k < NUM_LIGHTS) begin : g_used
                localparam logic [CNT_W-1:0] L_RST_COUNT = (k == 0)
                    ? CNT_W'(RST_GREEN)
                    : CNT_W'(k * (int'(RST_GREEN) + int'(RST_AMBER)));
                t_colour           w_col;
                logic [CNT_W-1:0]  w_reload_count;

                // The first light opens green for its own green time; the
                // others wait until the lights before them have finished.
                assign w_reload_count = (k == 0) ? CNT_W'(w_cfg.green[k])
                                                 : w_wait[k];

                tlseq_light #(
                    .P_FIRST     ((k == 0) ? 1'b1 : 1'b0),
                    .P_RST_COUNT (L_RST_COUNT)
                ) u_light (
                    .i_clk          (i_clk),
                    .i_rst_n        (i_rst_n),
                    .i_step         (w_step),
                    .i_green        (w_cfg.green[k]),
                    .i_amber        (w_cfg.amber),
                    .i_reload_count (w_reload_count),
                    .o_colour       (w_col),
                    .o_count        (w_count[k])
                );
                assign w_colour[k] = w_col;
            end else begin : g_unused
                // Lights that are not fitted always read red and holding.
                assign w_colour[k] = COL_RED;
                assign w_count[k]  = CNT_HOLD;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cycle     <= L_RST_CYCLE;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_cycle     <= n_cycle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_tick <= i_tick;
        end
    end

    // The state registers only change as a result is handed to the output,
    // so they hold the reported values for as long as the output waits.
    assign o_out_valid       = r_out_valid;
    assign o_colour_0        = w_colour[0];
    assign o_colour_1        = w_colour[1];
    assign o_colour_2        = w_colour[2];
    assign o_colour_3        = w_colour[3];
    assign o_remaining_0     = w_count[0];
    assign o_remaining_1     = w_count[1];
    assign o_remaining_2     = w_count[2];
    assign o_remaining_3     = w_count[3];
    assign o_cycle_remaining = r_cycle;

endmodule

// File: design/tlseq_cfg.sv
// ============================================================================
// tlseq_cfg: timing register file
// APB-style register port holding the four green times and the shared amber
// time. Writes land in the access phase, with pready always high; reads return the stored value.
// ============================================================================
module tlseq_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tlseq_pkg::ADDR_W-1:0] paddr,
    input  logic [tlseq_pkg::DATA_W-1:0] pwdata,
    output logic [tlseq_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output tlseq_pkg::t_cfg              o_cfg
);
    import tlseq_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_GREEN_0: n_cfg.green[0] = pwdata[TIME_W-1:0];
                REG_GREEN_1: n_cfg.green[1] = pwdata[TIME_W-1:0];
                REG_GREEN_2: n_cfg.green[2] = pwdata[TIME_W-1:0];
                REG_GREEN_3: n_cfg.green[3] = pwdata[TIME_W-1:0];
                REG_AMBER:   n_cfg.amber    = pwdata[TIME_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GREEN_0: prdata = DATA_W'(r_cfg.green[0]);
            REG_GREEN_1: prdata = DATA_W'(r_cfg.green[1]);
            REG_GREEN_2: prdata = DATA_W'(r_cfg.green[2]);
            REG_GREEN_3: prdata = DATA_W'(r_cfg.green[3]);
            REG_AMBER:   prdata = DATA_W'(r_cfg.amber);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.green <= {MAX_LIGHTS{RST_GREEN}};
            r_cfg.amber <= RST_AMBER;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tlseq_light.sv
// ============================================================================
// tlseq_light: state of one traffic light
// Holds the colour and countdown of one light and steps them on an advance
// or reload command.
// ============================================================================
module tlseq_light #(
    parameter logic                        P_FIRST     = 1'b0,
    parameter logic [tlseq_pkg::CNT_W-1:0] P_RST_COUNT = '0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tlseq_pkg::t_step             i_step,
    input  logic [tlseq_pkg::TIME_W-1:0] i_green,
    input  logic [tlseq_pkg::TIME_W-1:0] i_amber,
    input  logic [tlseq_pkg::CNT_W-1:0]  i_reload_count,
    output tlseq_pkg::t_colour           o_colour,
    output logic [tlseq_pkg::CNT_W-1:0]  o_count
);
    import tlseq_pkg::*;

    t_colour            r_colour;
    t_colour            n_colour;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_colour            w_colour;
    logic [CNT_W-1:0]   w_count;

    // Colour change when the countdown has run out.
    always_comb begin
        w_colour = r_colour;
        w_count  = r_count;
        if (r_count == '0) begin
            case (r_colour)
                COL_GREEN: begin
                    w_colour = COL_YELLOW;
                    w_count  = CNT_W'(i_amber);
                end
                COL_YELLOW: begin
                    w_colour = COL_RED;
                    w_count  = CNT_HOLD;
                end
                default: begin
                    w_colour = COL_GREEN;
                    w_count  = CNT_W'(i_green);
                end
            endcase
        end
    end

    always_comb begin
        n_colour = r_colour;
        n_count  = r_count;
        if (i_step.reload) begin
            n_colour = P_FIRST ? COL_GREEN : COL_RED;
            n_count  = i_reload_count;
        end else if (i_step.advance) begin
            n_colour = w_colour;
            n_count  = (w_count == CNT_HOLD) ? w_count : w_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= P_FIRST ? COL_GREEN : COL_RED;
            r_count  <= P_RST_COUNT;
        end else begin
            r_colour <= n_colour;
            r_count  <= n_count;
        end
    end

    assign o_colour = r_colour;
    assign o_count  = r_count;

endmodule
